// ===== rtl/mzts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mzts_pkg
// Shared types and constants of the multi-zone thermostat supervisor.
// ----------------------------------------------------------------------------
package mzts_pkg;

	// zones that are served; samples for higher zones are dropped
	localparam int ZONES = 3;

	localparam int TEMP_W  = 12;
	localparam int LIMIT_W = 24;
	localparam int ACK_W   = 16;
	localparam int WDOG_W  = 8;
	localparam int CLR_W   = 8;
	localparam int FLAG_W  = 4;
	localparam int BAND_W  = TEMP_W + 2;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_FAIL   = 2'd1,
		CMD_TICK   = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		ALM_IDLE   = 2'd0,
		ALM_ACTIVE = 2'd1,
		ALM_ACKED  = 2'd2
	} alarm_mode_t;

	typedef enum logic [2:0] {
		REG_CRITICAL = 3'd0,
		REG_ZONE0    = 3'd1,
		REG_ZONE1    = 3'd2,
		REG_ZONE2    = 3'd3,
		REG_ZONE3    = 3'd4,
		REG_ACK      = 3'd5,
		REG_WATCHDOG = 3'd6,
		REG_CLEAR    = 3'd7
	} reg_index_t;

	localparam logic signed [TEMP_W-1:0] CRITICAL_RESET = 12'sd800;
	localparam logic [ACK_W-1:0]  ACK_RESET      = 16'd40;
	localparam logic [WDOG_W-1:0] WATCHDOG_RESET = 8'd10;
	localparam logic [CLR_W-1:0]  CLEAR_RESET    = 8'd4;

	// setpoint / hysteresis reset per zone: 22.0/1.0, 18.0/2.0, 25.0/0.5, 0/0
	localparam logic [LIMIT_W-1:0] LIMIT_RESET [4] = '{
		24'd65888, 24'd131360, 24'd33168, 24'd0
	};

endpackage
`default_nettype wire

// ===== rtl/multi_zone_thermostat_supervisor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_zone_thermostat_supervisor_unit
// Per-zone hysteresis heater control with critical limit, sensor fault
// flags, fixed-window watchdog and an auto-acknowledging alarm.
// ----------------------------------------------------------------------------
//
// Channel   | Direction | Signals                          | Moves
// ----------+-----------+----------------------------------+---------------------
// s_axis    | in        | s_tvalid s_tready s_tdata s_tuser| sample / fail / tick
// m_axis    | out       | m_tvalid m_tready m_tdata        | one status per item
// cfg       | in        | cfg_valid cfg_ready cfg_index/data| register write
//
// Each input transfer lands in an input register; from there the state
// update and the status word are computed and captured in the result
// register. One item per cycle is sustained while m_tready is high. A
// stall on m_tready holds the result register and the input register;
// s_tready drops only when both are full.
// Reset clears all state, loads the register defaults and the watchdog
// window. cfg_ready is always high.
//
module multi_zone_thermostat_supervisor_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [15:0] s_tdata,   // [1:0] zone, [13:2] temperature, [15:14] zero
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [15:0] m_tdata,   // [3:0] heater_bits, [4] buzzer,
	                                    // [6:5] alarm_mode, [10:7] fault_bits,
	                                    // [14:11] critical_bits, [15] zero
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int Z = mzts_pkg::ZONES;
	localparam int TW = mzts_pkg::TEMP_W;
	localparam int BW = mzts_pkg::BAND_W;

	// configuration registers
	logic signed [TW-1:0]             crit_lim_q;
	logic [mzts_pkg::LIMIT_W-1:0]     limits_q [Z];
	logic [mzts_pkg::ACK_W-1:0]       ack_ticks_q;
	logic [mzts_pkg::WDOG_W-1:0]      wdog_ticks_q;
	logic [mzts_pkg::CLR_W-1:0]       clr_ticks_q;

	// input stage
	logic                 valid_s1;
	logic [1:0]           cmd_s1;
	logic [1:0]           zone_s1;
	logic signed [TW-1:0] temp_s1;

	// supervisor state
	logic signed [TW-1:0]          temp_q [Z];
	logic [Z-1:0]                  fault_q, crit_q, heat_q, checkin_q;
	mzts_pkg::alarm_mode_t         alarm_q;
	logic [mzts_pkg::ACK_W-1:0]    alarm_tmr_q;
	logic [mzts_pkg::WDOG_W-1:0]   wdog_q;
	logic [mzts_pkg::CLR_W-1:0]    clr_q;

	// next state
	logic [Z-1:0]                  fault_n, crit_n, heat_n, checkin_n;
	mzts_pkg::alarm_mode_t         alarm_n;
	logic [mzts_pkg::ACK_W-1:0]    alarm_tmr_n;
	logic [mzts_pkg::WDOG_W-1:0]   wdog_n;
	logic [mzts_pkg::CLR_W-1:0]    clr_n;

	logic                 out_valid_q;
	logic [15:0]          out_data_q;
	logic                 advance;
	logic                 zone_ok;
	logic [Z-1:0]         zbit;
	logic [3:0]           heat_o, fault_o, crit_o;

	// the result register frees when it is empty or being taken
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	assign zone_ok = (int'(zone_s1) < Z);
	assign zbit    = Z'(1) << zone_s1;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_lim_q   <= mzts_pkg::CRITICAL_RESET;
			ack_ticks_q  <= mzts_pkg::ACK_RESET;
			wdog_ticks_q <= mzts_pkg::WATCHDOG_RESET;
			clr_ticks_q  <= mzts_pkg::CLEAR_RESET;
			for (int i = 0; i < Z; i++) begin
				limits_q[i] <= mzts_pkg::LIMIT_RESET[i];
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				mzts_pkg::REG_CRITICAL: crit_lim_q   <= cfg_data[TW-1:0];
				mzts_pkg::REG_ACK:      ack_ticks_q  <= cfg_data[mzts_pkg::ACK_W-1:0];
				mzts_pkg::REG_WATCHDOG: wdog_ticks_q <= cfg_data[mzts_pkg::WDOG_W-1:0];
				mzts_pkg::REG_CLEAR:    clr_ticks_q  <= cfg_data[mzts_pkg::CLR_W-1:0];
				default: begin
					// zone limit registers; writes for unserved zones are dropped
					for (int i = 0; i < Z; i++) begin
						if (int'(cfg_index) == int'(mzts_pkg::REG_ZONE0) + i) begin
							limits_q[i] <= cfg_data;
						end
					end
				end
			endcase
		end
	end

	// ----------------------------------------------------------- input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			zone_s1 <= s_tdata[1:0];
			temp_s1 <= s_tdata[13:2];
		end
	end

	// ------------------------------------------------------ next-state logic
	always_comb begin
		logic signed [BW-1:0] sp, hy, tz;
		logic                 clr_all;
		logic                 trig;
		logic                 crit_now;

		fault_n     = fault_q;
		crit_n      = crit_q;
		heat_n      = heat_q;
		checkin_n   = checkin_q;
		alarm_n     = alarm_q;
		alarm_tmr_n = alarm_tmr_q;
		wdog_n      = wdog_q;
		clr_n       = clr_q;
		clr_all     = ((fault_q | crit_q) == '0);
		trig        = 1'b0;
		crit_now    = (temp_s1 >= crit_lim_q);
		sp          = '0;
		hy          = '0;
		tz          = '0;

		case (cmd_s1)
			mzts_pkg::CMD_SAMPLE: begin
				if (zone_ok) begin
					fault_n   = fault_q & ~zbit;
					crit_n    = crit_now ? (crit_q | zbit) : (crit_q & ~zbit);
					checkin_n = checkin_q | zbit;
					trig      = crit_now;
				end
			end
			mzts_pkg::CMD_FAIL: begin
				if (zone_ok && ((fault_q & zbit) == '0)) begin
					fault_n = fault_q | zbit;
					trig    = 1'b1;
				end
			end
			mzts_pkg::CMD_TICK: begin
				// heaters: forced off unless alarm idle and zone healthy
				for (int i = 0; i < Z; i++) begin
					sp = BW'(signed'(limits_q[i][TW-1:0]));
					hy = BW'(limits_q[i][2*TW-1:TW]);
					tz = BW'(temp_q[i]);
					if (alarm_q != mzts_pkg::ALM_IDLE || fault_q[i] || crit_q[i]) begin
						heat_n[i] = 1'b0;
					end else if (tz < sp - hy) begin
						heat_n[i] = 1'b1;
					end else if (tz > sp + hy) begin
						heat_n[i] = 1'b0;
					end
				end

				// alarm timers
				case (alarm_q)
					mzts_pkg::ALM_ACTIVE: begin
						if (alarm_tmr_q <= 1) begin
							alarm_tmr_n = '0;
							if (clr_all) begin
								alarm_n = mzts_pkg::ALM_IDLE;
							end else begin
								alarm_n = mzts_pkg::ALM_ACKED;
								clr_n   = clr_ticks_q;
							end
						end else begin
							alarm_tmr_n = alarm_tmr_q - 1'b1;
						end
					end
					mzts_pkg::ALM_ACKED: begin
						if (clr_q <= 1) begin
							if (clr_all) begin
								alarm_n = mzts_pkg::ALM_IDLE;
								clr_n   = '0;
							end else begin
								clr_n = clr_ticks_q;
							end
						end else begin
							clr_n = clr_q - 1'b1;
						end
					end
					default: ;
				endcase

				// watchdog window
				if (wdog_q > 1) begin
					wdog_n = wdog_q - 1'b1;
				end else begin
					for (int i = 0; i < Z; i++) begin
						if (!checkin_q[i] && !fault_q[i]) begin
							fault_n[i] = 1'b1;
							trig       = 1'b1;
						end else if (checkin_q[i] && fault_q[i]) begin
							fault_n[i] = 1'b0;
						end
					end
					checkin_n = '0;
					wdog_n    = wdog_ticks_q;
				end
			end
			default: ;
		endcase

		// a trigger starts the alarm only when the next alarm mode is idle
		if (trig && alarm_n == mzts_pkg::ALM_IDLE) begin
			alarm_n     = mzts_pkg::ALM_ACTIVE;
			alarm_tmr_n = ack_ticks_q;
		end
	end

	// ----------------------------------------------------------- state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q     <= '0;
			crit_q      <= '0;
			heat_q      <= '0;
			checkin_q   <= '0;
			alarm_q     <= mzts_pkg::ALM_IDLE;
			alarm_tmr_q <= '0;
			wdog_q      <= mzts_pkg::WATCHDOG_RESET;
			clr_q       <= '0;
			for (int i = 0; i < Z; i++) begin
				temp_q[i] <= '0;
			end
		end else if (advance) begin
			fault_q     <= fault_n;
			crit_q      <= crit_n;
			heat_q      <= heat_n;
			checkin_q   <= checkin_n;
			alarm_q     <= alarm_n;
			alarm_tmr_q <= alarm_tmr_n;
			wdog_q      <= wdog_n;
			clr_q       <= clr_n;
			if (cmd_s1 == mzts_pkg::CMD_SAMPLE && zone_ok) begin
				temp_q[zone_s1] <= temp_s1;
			end
		end
	end

	// ------------------------------------------------------- result register
	// unserved zones read as zero
	assign heat_o  = mzts_pkg::FLAG_W'(heat_n);
	assign fault_o = mzts_pkg::FLAG_W'(fault_n);
	assign crit_o  = mzts_pkg::FLAG_W'(crit_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {1'b0, crit_o, fault_o, alarm_n,
				(alarm_n == mzts_pkg::ALM_ACTIVE), heat_o};
		end
	end

	// ------------------------------------------------------------ assertions
	a_buzzer_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[4] == (out_data_q[6:5] == mzts_pkg::ALM_ACTIVE)))
		else $error("buzzer does not follow alarm mode");

	a_heaters_off_in_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == mzts_pkg::CMD_TICK && alarm_q != mzts_pkg::ALM_IDLE)
		|=> (heat_q == '0))
		else $error("heater left on during alarm tick");

	a_state_holds_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(fault_q) && $stable(alarm_q) && $stable(wdog_q)))
		else $error("state changed without an item");

endmodule
`default_nettype wire
